### src/ffwq_pkg.sv
// ----------------------------------------------------------------------------
// First-fit wait queue package
// Shared widths, mode and status codes, and the stored entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package ffwq_pkg;

    localparam int FFWQ_CAPACITY = 16;

    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int SIZE_W     = 8;
    localparam int LOW_W      = 64;
    localparam int MID_W      = 64;
    localparam int HIGH_W     = 24;
    localparam int NAME_W     = LOW_W + MID_W + HIGH_W;
    localparam int NAME_BYTES = NAME_W / 8;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIST   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_REMOVED = 3'd3,
        ST_NOFIT   = 3'd4,
        ST_EMPTY   = 3'd5,
        ST_ENTRY   = 3'd6
    } status_t;

    typedef struct packed {
        logic [HIGH_W-1:0] name_high;
        logic [MID_W-1:0]  name_mid;
        logic [LOW_W-1:0]  name_low;
        logic [SIZE_W-1:0] size;
    } entry_t;

endpackage

`default_nettype wire

### src/ffwq_if.sv
// ----------------------------------------------------------------------------
// First-fit wait queue channels
// Request and response channels with valid/ready transfer handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffwq_req_if import ffwq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LOW_W-1:0]  name_low;
    logic [MID_W-1:0]  name_mid;
    logic [HIGH_W-1:0] name_high;
    logic [SIZE_W-1:0] party_size;
    logic [SIZE_W-1:0] free_size;

    modport source (output valid, mode, name_low, name_mid, name_high, party_size,
                    free_size, input ready);
    modport sink (input valid, mode, name_low, name_mid, name_high, party_size,
                  free_size, output ready);
endinterface

interface ffwq_rsp_if import ffwq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [LOW_W-1:0]    out_name_low;
    logic [MID_W-1:0]    out_name_mid;
    logic [HIGH_W-1:0]   out_name_high;
    logic [SIZE_W-1:0]   out_size;
    logic                last;

    modport source (output valid, status, out_name_low, out_name_mid, out_name_high,
                    out_size, last, input ready);
    modport sink (input valid, status, out_name_low, out_name_mid, out_name_high,
                  out_size, last, output ready);
endinterface

`default_nettype wire

### src/ffwq_store.sv
// ----------------------------------------------------------------------------
// First-fit wait queue entry store
// Entry memory with one write port and one registered, enabled read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffwq_store import ffwq_pkg::*; #(
    parameter int DEPTH = FFWQ_CAPACITY,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/first_fit_wait_queue.sv
// ----------------------------------------------------------------------------
// First-fit wait queue
// Ordered queue of named requests with add, first-fit remove and list.
// ----------------------------------------------------------------------------
// The request channel carries a mode, a 19-byte name and two sizes; the
// response channel carries a status, an entry and a last flag. Both use
// valid/ready, and a transfer happens when both are high.
// Add checks every held entry for an equal name, one entry per cycle, then
// appends if the queue has room. Remove walks the entries oldest first at
// one per cycle until one fits, then closes the gap by moving each later
// entry down, one per cycle. List emits one response per held entry, one
// per cycle while the receiver takes them.
// This pace is set by the single read port of the entry memory, which every
// walk goes through. A new request is taken only when the previous one has
// finished; its last response may still wait in the output register.
// Unused mode 3 is taken and gives no response.
// When the receiver stalls, the walk holds at the next response to emit.
// Reset empties the queue at once; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_wait_queue import ffwq_pkg::*; #(
    parameter int CAPACITY = FFWQ_CAPACITY
) (
    input  logic  clk,
    input  logic  rst_n,
    ffwq_req_if.sink   req,
    ffwq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    entry_t            key_reg, key_next;
    logic [SIZE_W-1:0] limit_reg, limit_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  hit_reg, hit_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    entry_t            out_entry_reg, out_entry_next;
    logic              out_last_reg, out_last_next;

    logic              st_wr_en;
    logic [IDX_W-1:0]  st_wr_addr;
    entry_t            st_wr_data;
    logic              st_rd_en;
    entry_t            st_rd_data;

    logic              out_free;
    logic              out_load;
    logic              issue;
    logic              name_eq;
    logic              size_fit;
    logic              scan_hit;
    logic              scan_done;
    logic              advance;
    logic [NAME_W-1:0] norm;

    function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic              ended;
        res   = raw;
        ended = 1'b0;
        for (int k = 0; k < NAME_BYTES; k++)
        begin
            if (ended)
            begin
                res[8*k +: 8] = 8'h00;
            end
            else if (raw[8*k +: 8] == 8'h00)
            begin
                ended = 1'b1;
            end
        end
        return res;
    endfunction

    ffwq_store #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (st_rd_data)
    );

    assign norm      = norm_name({req.name_high, req.name_mid, req.name_low});
    assign out_free  = !out_valid_reg || rsp.ready;
    assign issue     = (idx_reg < count_reg);
    assign name_eq   = (st_rd_data.name_low == key_reg.name_low) &&
                       (st_rd_data.name_mid == key_reg.name_mid) &&
                       (st_rd_data.name_high == key_reg.name_high);
    assign size_fit  = (st_rd_data.size <= limit_reg);
    assign scan_hit  = pend_reg && (((mode_reg == MODE_ADD) && name_eq) ||
                                    ((mode_reg == MODE_REMOVE) && size_fit) ||
                                    (mode_reg == MODE_LIST));
    assign scan_done = !pend_reg && !issue;
    assign advance   = !((scan_hit || scan_done) && !out_free);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        limit_next      = limit_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        wr_idx_next     = wr_idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        st_wr_en        = 1'b0;
        st_wr_addr      = wr_idx_reg;
        st_wr_data      = st_rd_data;
        st_rd_en        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && (req.mode != MODE_NONE))
                begin
                    state_next         = S_SCAN;
                    mode_next          = req.mode;
                    key_next.name_low  = norm[LOW_W-1:0];
                    key_next.name_mid  = norm[LOW_W +: MID_W];
                    key_next.name_high = norm[LOW_W + MID_W +: HIGH_W];
                    key_next.size      = req.party_size;
                    limit_next         = req.free_size;
                    idx_next           = '0;
                    pend_next          = 1'b0;
                end
            end

            S_SCAN:
            begin
                if (advance)
                begin
                    if (issue)
                    begin
                        st_rd_en  = 1'b1;
                        idx_next  = idx_reg + CNT_W'(1);
                        pend_next = 1'b1;
                        hit_next  = idx_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end

                if (scan_hit && out_free)
                begin
                    out_load       = 1'b1;
                    out_entry_next = st_rd_data;
                    out_last_next  = 1'b1;
                    case (mode_reg)
                        MODE_ADD:
                        begin
                            out_status_next = ST_DUP;
                            out_entry_next  = '0;
                            state_next      = S_IDLE;
                        end
                        MODE_REMOVE:
                        begin
                            out_status_next = ST_REMOVED;
                            wr_idx_next     = hit_reg;
                            state_next      = S_SHIFT;
                        end
                        default:
                        begin
                            out_status_next = ST_ENTRY;
                            out_last_next   = (CNT_W'(hit_reg) == count_reg - CNT_W'(1));
                            if (out_last_next)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                    endcase
                end
                else if (scan_done && out_free)
                begin
                    state_next     = S_IDLE;
                    out_entry_next = '0;
                    out_last_next  = 1'b1;
                    case (mode_reg)
                        MODE_ADD:
                        begin
                            out_load = 1'b1;
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                out_status_next = ST_ADDED;
                                st_wr_en        = 1'b1;
                                st_wr_addr      = count_reg[IDX_W-1:0];
                                st_wr_data      = key_reg;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_REMOVE:
                        begin
                            out_load        = 1'b1;
                            out_status_next = (count_reg == '0) ? ST_EMPTY : ST_NOFIT;
                        end
                        default:
                        begin
                            out_load        = (count_reg == '0);
                            out_status_next = ST_EMPTY;
                        end
                    endcase
                end

                if (out_load)
                begin
                    out_valid_next = 1'b1;
                end
            end

            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    st_wr_en    = 1'b1;
                    wr_idx_next = wr_idx_reg + IDX_W'(1);
                end
                if (issue)
                begin
                    st_rd_en  = 1'b1;
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (scan_done)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_ADD;
            key_reg        <= '0;
            limit_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= '0;
            wr_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_ADDED;
            out_entry_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            key_reg        <= key_next;
            limit_reg      <= limit_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
            wr_idx_reg     <= wr_idx_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_entry_reg  <= out_entry_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.out_name_low  = out_entry_reg.name_low;
    assign rsp.out_name_mid  = out_entry_reg.name_mid;
    assign rsp.out_name_high = out_entry_reg.name_high;
    assign rsp.out_size      = out_entry_reg.size;
    assign rsp.last          = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) ||
                  count_reg == $past(count_reg) + CNT_W'(1) ||
                  count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_wr_en |-> (CNT_W'(st_wr_addr) <= count_reg))
        else $error("store write beyond the held entries");

    a_no_response_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> !out_load)
        else $error("response loaded while closing the gap");

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// First-fit wait queue testbench
// Drives add, remove, list and unused requests through the request channel,
// predicts every response from a private copy of the queue, and checks each
// response transfer field by field. Both channels stall at random, with one
// long stretch where neither side holds back.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffwq_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 64;
    localparam int STALL_PCT    = 32;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LOW_W-1:0]  name_low;
        logic [MID_W-1:0]  name_mid;
        logic [HIGH_W-1:0] name_high;
        logic [SIZE_W-1:0] party_size;
        logic [SIZE_W-1:0] free_size;
        logic              drain;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [LOW_W-1:0]  name_low;
        logic [MID_W-1:0]  name_mid;
        logic [HIGH_W-1:0] name_high;
        logic [SIZE_W-1:0] size;
        logic              last;
    } rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic drv_valid = 1'b0;
    logic mon_ready = 1'b0;
    req_t drv_item = '0;
    logic quiet;

    req_t   req_backlog[$];
    rsp_t   rsp_due[$];
    entry_t held[FFWQ_CAPACITY];
    int     held_count = 0;
    int     reqs_taken = 0;
    int     rsps_checked = 0;
    int     mismatches = 0;
    int     cycles = 0;
    int     status_seen[8];

    ffwq_req_if req_ch();
    ffwq_rsp_if rsp_ch();

    assign req_ch.valid      = drv_valid;
    assign req_ch.mode       = drv_item.mode;
    assign req_ch.name_low   = drv_item.name_low;
    assign req_ch.name_mid   = drv_item.name_mid;
    assign req_ch.name_high  = drv_item.name_high;
    assign req_ch.party_size = drv_item.party_size;
    assign req_ch.free_size  = drv_item.free_size;
    assign rsp_ch.ready      = mon_ready;

    assign quiet = (reqs_taken >= 120) && (reqs_taken < 170);

    first_fit_wait_queue i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] nm;
        bit ended;
        nm = raw;
        ended = 1'b0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (ended)
                nm[8*k +: 8] = 8'h00;
            else if (nm[8*k +: 8] == 8'h00)
                ended = 1'b1;
        end
        return nm;
    endfunction

    function automatic logic [NAME_W-1:0] with_junk(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] nm;
        bit ended;
        nm = raw;
        ended = 1'b0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (ended)
                nm[8*k +: 8] = 8'($urandom);
            else if (nm[8*k +: 8] == 8'h00)
                ended = 1'b1;
        end
        return nm;
    endfunction

    function automatic logic [NAME_W-1:0] fresh_name(input int len);
        logic [NAME_W-1:0] nm;
        nm = '0;
        for (int k = 0; k < len && k < NAME_BYTES; k++)
            nm[8*k +: 8] = 8'($urandom_range(255, 1));
        return nm;
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return SIZE_W'($urandom_range(255));
    endfunction

    function automatic void push_item(input logic [MODE_W-1:0] mode,
                                      input logic [NAME_W-1:0] nm,
                                      input logic [SIZE_W-1:0] party,
                                      input logic [SIZE_W-1:0] free,
                                      input logic drain);
        req_t r;
        r.mode       = mode;
        r.name_low   = nm[LOW_W-1:0];
        r.name_mid   = nm[LOW_W +: MID_W];
        r.name_high  = nm[LOW_W+MID_W +: HIGH_W];
        r.party_size = party;
        r.free_size  = free;
        r.drain      = drain;
        req_backlog.push_back(r);
    endfunction

    task automatic apply_request(input req_t r);
        logic [NAME_W-1:0] nm;
        rsp_t res;
        bit dup;
        int hit;
        res = '0;
        res.last = 1'b1;
        case (r.mode)
            MODE_ADD: begin
                nm = trim_name({r.name_high, r.name_mid, r.name_low});
                dup = 1'b0;
                for (int i = 0; i < held_count; i++)
                    if ({held[i].name_high, held[i].name_mid, held[i].name_low} == nm)
                        dup = 1'b1;
                if (dup) begin
                    res.status = ST_DUP;
                end else if (held_count >= FFWQ_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    held[held_count] = {nm, r.party_size};
                    held_count++;
                    res.status = ST_ADDED;
                end
                rsp_due.push_back(res);
            end
            MODE_REMOVE: begin
                hit = -1;
                for (int i = 0; i < held_count; i++)
                    if (hit < 0 && held[i].size <= r.free_size)
                        hit = i;
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (hit < 0) begin
                    res.status = ST_NOFIT;
                end else begin
                    res.status    = ST_REMOVED;
                    res.name_low  = held[hit].name_low;
                    res.name_mid  = held[hit].name_mid;
                    res.name_high = held[hit].name_high;
                    res.size      = held[hit].size;
                    for (int j = hit; j + 1 < held_count; j++)
                        held[j] = held[j + 1];
                    held_count--;
                end
                rsp_due.push_back(res);
            end
            MODE_LIST: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                    rsp_due.push_back(res);
                end
                for (int i = 0; i < held_count; i++) begin
                    res.status    = ST_ENTRY;
                    res.name_low  = held[i].name_low;
                    res.name_mid  = held[i].name_mid;
                    res.name_high = held[i].name_high;
                    res.size      = held[i].size;
                    res.last      = (i == held_count - 1);
                    rsp_due.push_back(res);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("response %0d %s got %0h, want %0h",
                                      rsps_checked, field, got, want));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
            drv_item  <= '0;
        end else begin
            if (drv_valid && req_ch.ready) begin
                apply_request(drv_item);
                reqs_taken++;
            end
            if (!drv_valid || req_ch.ready) begin
                if (req_backlog.size() != 0 && (quiet || $urandom_range(99) >= STALL_PCT)
                        && !(req_backlog[0].drain && (rsp_due.size() != 0 || drv_valid))) begin
                    drv_item  <= req_backlog.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            mon_ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && mon_ready) begin
                if (rsp_due.size() == 0) begin
                    report_mismatch($sformatf("response with status %0d and nothing outstanding",
                                              rsp_ch.status));
                end else begin
                    want = rsp_due.pop_front();
                    check_field("status", 64'(rsp_ch.status), 64'(want.status));
                    check_field("out_name_low", rsp_ch.out_name_low, want.name_low);
                    check_field("out_name_mid", rsp_ch.out_name_mid, want.name_mid);
                    check_field("out_name_high", 64'(rsp_ch.out_name_high),
                                64'(want.name_high));
                    check_field("out_size", 64'(rsp_ch.out_size), 64'(want.size));
                    check_field("last", 64'(rsp_ch.last), 64'(want.last));
                    status_seen[want.status]++;
                end
                rsps_checked++;
            end
            mon_ready <= quiet || ($urandom_range(99) >= STALL_PCT);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("[first_fit_wait_queue] ERROR");
            $finish;
        end
    end

    initial begin
        logic [NAME_W-1:0] nm;
        logic [NAME_W-1:0] name_pool[$];
        int add_pct;
        int rem_pct;
        int unsigned pick;

        // Empty queue, unused mode, the widest and the empty name, and a name
        // whose bytes past the terminator differ but which still matches.
        push_item(MODE_LIST, '0, '0, '0, 1'b0);
        push_item(MODE_REMOVE, '0, '0, '0, 1'b0);
        push_item(MODE_NONE, '1, '1, '1, 1'b0);
        push_item(MODE_ADD, '1, 8'd255, 8'd0, 1'b0);
        push_item(MODE_ADD, '0, 8'd0, 8'd255, 1'b0);
        nm = with_junk(fresh_name(1));
        push_item(MODE_ADD, nm, 8'd200, 8'd0, 1'b0);
        push_item(MODE_ADD, with_junk(nm), 8'd7, 8'd0, 1'b0);
        push_item(MODE_REMOVE, '0, 8'd99, 8'd0, 1'b0);
        push_item(MODE_REMOVE, '0, 8'd0, 8'd9, 1'b0);
        for (int k = 0; k < 14; k++)
            push_item(MODE_ADD, with_junk(fresh_name(19 - k)), rand_size(), '0, 1'b0);
        push_item(MODE_ADD, '1, 8'd1, 8'd0, 1'b0);
        push_item(MODE_ADD, fresh_name(3), 8'd1, 8'd0, 1'b0);
        push_item(MODE_LIST, '0, '0, '0, 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 3)
                0: begin
                    add_pct = 60;
                    rem_pct = 85;
                end
                1: begin
                    add_pct = 25;
                    rem_pct = 82;
                end
                default: begin
                    add_pct = 45;
                    rem_pct = 82;
                end
            endcase
            for (int n = 0; n < 29; n++) begin
                pick = $urandom_range(99);
                if (pick < add_pct) begin
                    case ($urandom_range(9))
                        7, 8: nm = name_pool.size() != 0 ?
                                   name_pool[$urandom_range(name_pool.size() - 1)] :
                                   fresh_name($urandom_range(19));
                        9: nm = NAME_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
                        default: nm = fresh_name($urandom_range(19));
                    endcase
                    if ($urandom_range(1) == 1)
                        nm = with_junk(nm);
                    name_pool.push_back(nm);
                    push_item(MODE_ADD, nm, rand_size(), rand_size(), n == 0);
                end else if (pick < rem_pct) begin
                    push_item(MODE_REMOVE, fresh_name(19), rand_size(), rand_size(), n == 0);
                end else if (pick < 97) begin
                    push_item(MODE_LIST, fresh_name(19), rand_size(), rand_size(), n == 0);
                end else begin
                    push_item(MODE_NONE, fresh_name(19), rand_size(), rand_size(), n == 0);
                end
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (req_backlog.size() != 0 || drv_valid || rsp_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests and checked %0d responses against the predicted queue.",
                 reqs_taken, rsps_checked);
        $display("Seen: %0d added, %0d duplicate, %0d full, %0d removed, %0d no fit, %0d empty, %0d listed.",
                 status_seen[ST_ADDED], status_seen[ST_DUP], status_seen[ST_FULL],
                 status_seen[ST_REMOVED], status_seen[ST_NOFIT], status_seen[ST_EMPTY],
                 status_seen[ST_ENTRY]);
        if (mismatches == 0)
            $display("[first_fit_wait_queue] OK");
        else
            $display("[first_fit_wait_queue] ERROR");
        $finish;
    end
endmodule

### first_fit_wait_queue.f
src/ffwq_pkg.sv
src/ffwq_if.sv
src/ffwq_store.sv
src/first_fit_wait_queue.sv
bench/tb.sv
